/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* hw/rtl/modexp_pkg.sv */
// ----------------------------------------------------------------------------
// modexp_pkg
// Widths, register indexes and the request/response types of the
// modular multiplier shared by the exponentiation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package modexp_pkg;

    // Key, message and result width
    localparam int KEY_WIDTH = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd1;

    // Request to the bit-serial modular multiplier: result = a * b mod m
    typedef struct packed {
        logic                 start;
        logic [KEY_WIDTH-1:0] a;
        logic [KEY_WIDTH-1:0] b;
    } t_mm_req;

    // Response: done pulses for one cycle with the product valid
    typedef struct packed {
        logic                 done;
        logic [KEY_WIDTH-1:0] result;
    } t_mm_rsp;

endpackage

/* hw/rtl/modexp_mulmod.sv */
// ----------------------------------------------------------------------------
// modexp_mulmod
// Interleaved bit-serial modular multiplier. Scans b from the MSB, one bit
// per cycle: r = 2r + b_i * a, then reduces by subtracting m or 2m.
// Needs a <= m and r < m on entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modexp_mulmod (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  modexp_pkg::t_mm_req                i_req,
    input  logic [modexp_pkg::KEY_WIDTH:0]     i_mod,   // 2^KEY_WIDTH allowed
    output modexp_pkg::t_mm_rsp                o_rsp
);

    localparam int KW    = modexp_pkg::KEY_WIDTH;
    localparam int CNT_W = $clog2(KW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [KW-1:0]    r_a;
    logic [KW-1:0]    r_b;
    logic [KW-1:0]    r_r;

    logic [KW-1:0]    w_add;
    logic [KW+1:0]    w_t;
    logic [KW+1:0]    w_m1;
    logic [KW+1:0]    w_m2;
    logic [KW+1:0]    w_d;
    logic [KW-1:0]    n_r;

    // One step: double, add partial product, reduce (sum stays below 3m)
    always_comb begin
        w_add = r_b[KW-1] ? r_a : '0;
        w_t   = {1'b0, r_r, 1'b0} + {2'b00, w_add};
        w_m1  = {1'b0, i_mod};
        w_m2  = {i_mod, 1'b0};
        priority if (w_t >= w_m2) begin
            w_d = w_t - w_m2;
        end else if (w_t >= w_m1) begin
            w_d = w_t - w_m1;
        end else begin
            w_d = w_t;
        end
        n_r = w_d[KW-1:0];
    end

    // Sequencer and datapath shift registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // done pulses after the last step of a run
            r_done <= r_busy && !i_req.start && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(KW - 1);
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_r    <= '0;
            end else if (r_busy) begin
                r_r <= n_r;
                r_b <= {r_b[KW-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_r;

    `ASSERT_NEVER(a_start_while_busy, i_req.start && r_busy,
                  "mulmod: new request while a product is in progress")
    `ASSERT_CLK(a_done_after_last, r_done |-> !r_busy && $past(r_busy),
                "mulmod: done without a finished run")
    `ASSERT_CLK(a_result_reduced, r_done |-> ({1'b0, r_r} < i_mod),
                "mulmod: result not reduced below modulus")

endmodule

/* hw/rtl/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes message^exponent mod modulus by right-to-left square and
// multiply on one shared bit-serial modular multiplier.
//
//   channel  direction  handshake                payload
//   input    in         i_in_valid / o_in_stall  i_message
//   output   out        o_out_valid / i_out_stall o_power_result
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request at a time. The message is first reduced mod modulus on the
// multiplier. Each exponent bit up to the highest set one costs a squaring,
// plus a multiply when the bit is set; the highest set bit skips its
// squaring. Reset is synchronous, active low; it restores exponent 1,
// modulus 65535. A new request is taken while a finished result still
// waits in the output register; a stalled output only delays the next
// result's write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modular_exponentiation (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [modexp_pkg::KEY_WIDTH-1:0]      i_message,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [modexp_pkg::KEY_WIDTH-1:0]      o_power_result,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [modexp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [modexp_pkg::KEY_WIDTH-1:0]      i_cfg_data
);

    localparam int KW = modexp_pkg::KEY_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_BIT,
        S_MUL,
        S_SQR,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [KW-1:0]        r_exponent;
    logic [KW-1:0]        r_modulus;
    logic [KW-1:0]        r_e;
    logic [KW-1:0]        r_acc;
    logic [KW-1:0]        r_base;
    logic                 r_out_valid;
    logic [KW-1:0]        r_out_data;
    modexp_pkg::t_mm_req  r_req;
    modexp_pkg::t_mm_rsp  w_rsp;
    logic [KW:0]          w_mod;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 n_req_start;

    // Zero modulus stands for 2^KEY_WIDTH
    assign w_mod      = (r_modulus == '0) ? {1'b1, {KW{1'b0}}} : {1'b0, r_modulus};
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Multiplier start: new request, bit with work left, squaring after a multiply
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_req_start = w_in_acc;
            S_BIT:   n_req_start = (r_e != '0);
            S_MUL:   n_req_start = w_rsp.done && (r_e[KW-1:1] != '0);
            default: n_req_start = 1'b0;
        endcase
    end

    // Configuration registers; always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= KW'(1);
            r_modulus  <= KW'(65535);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                modexp_pkg::REG_EXPONENT: r_exponent <= i_cfg_data;
                modexp_pkg::REG_MODULUS:  r_modulus  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Square-and-multiply sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_req.start <= n_req_start;
            // output register: load on completion, drop once taken
            priority if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        // reduce the message: 1 * message mod m
                        r_e         <= r_exponent;
                        r_acc       <= KW'(1);
                        r_req.a     <= KW'(1);
                        r_req.b     <= i_message;
                        r_state     <= S_RED;
                    end
                end
                S_RED: begin
                    if (w_rsp.done) begin
                        r_base  <= w_rsp.result;
                        r_state <= S_BIT;
                    end
                end
                S_BIT: begin
                    priority if (r_e == '0) begin
                        r_state <= S_OUT;
                    end else if (r_e[0]) begin
                        r_req.a     <= r_acc;
                        r_req.b     <= r_base;
                        r_state     <= S_MUL;
                    end else begin
                        r_req.a     <= r_base;
                        r_req.b     <= r_base;
                        r_state     <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (w_rsp.done) begin
                        r_acc <= w_rsp.result;
                        // last set bit: the final squaring is not needed
                        if (r_e[KW-1:1] == '0) begin
                            r_e     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_req.a     <= r_base;
                            r_req.b     <= r_base;
                            r_state     <= S_SQR;
                        end
                    end
                end
                S_SQR: begin
                    if (w_rsp.done) begin
                        r_base  <= w_rsp.result;
                        r_e     <= r_e >> 1;
                        r_state <= S_BIT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_data  <= r_acc;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    modexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_mod   (w_mod),
        .o_rsp   (w_rsp)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_out_data;
    assign o_cfg_ready    = 1'b1;

    `ASSERT_CLK(a_accept_starts_reduce, w_in_acc |=> r_state == S_RED && r_req.start,
                "modexp: accepted request did not start the reduction")
    `ASSERT_CLK(a_done_only_when_waiting,
                w_rsp.done |-> r_state == S_RED || r_state == S_MUL || r_state == S_SQR,
                "modexp: multiplier result arrived with no one waiting")
    `ASSERT_CLK(a_result_not_overwritten,
                (r_state == S_OUT && r_out_valid && i_out_stall) |=> r_state == S_OUT,
                "modexp: pending result overwritten while output stalled")

endmodule

/* dv/modular_exponentiation_tb.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the square-and-multiply exponentiation block.
// A directed table covers reset keys, zero exponent, modulus of one and of
// zero, unreduced messages and writes to unused register indexes. A random
// part then runs about 1100 requests over a series of key settings. Every
// result is checked in order against a table value or an in-bench model of
// message^exponent mod modulus, with bursty requests and a stalling consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation_tb;

    localparam int KEY_WIDTH = modexp_pkg::KEY_WIDTH;
    localparam int CFG_IDX_W = modexp_pkg::CFG_IDX_W;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = modexp_pkg::REG_EXPONENT;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = modexp_pkg::REG_MODULUS;

    localparam int CYCLE_LIMIT    = 6_000_000;
    localparam int DRAIN_CYCLES   = 700;
    localparam int KEY_PHASES     = 12;
    localparam int PHASE_REQUESTS = 92;
    localparam int DIRECTED_ROWS  = 33;

    // Indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic {ROW_REQ, ROW_KEY} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [KEY_WIDTH-1:0]   value;
        bit                     typed;
        logic [KEY_WIDTH-1:0]   want;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [KEY_WIDTH-1:0]   i_message = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [KEY_WIDTH-1:0]   o_power_result;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [KEY_WIDTH-1:0]   i_cfg_data = '0;

    // Bench copy of the key registers
    logic [KEY_WIDTH-1:0]   key_exp = 16'd1;
    logic [KEY_WIDTH-1:0]   key_mod = 16'd65535;

    logic [KEY_WIDTH-1:0]   pending_powers[$];
    t_stim_row              directed_rows[DIRECTED_ROWS];

    int mismatches      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int key_writes      = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    int stall_window    = 0;
    int stall_mode      = 0;

    modular_exponentiation dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_message      (i_message),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_power_result (o_power_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Model of the arithmetic
    // ------------------------------------------------------------------

    // Zero modulus stands for 2^KEY_WIDTH
    function automatic logic [63:0] reduce_by_key(logic [63:0] x);
        if (key_mod == '0) begin
            return x & ((64'd1 << KEY_WIDTH) - 64'd1);
        end
        return x % key_mod;
    endfunction

    // Right-to-left square and multiply; accumulator starts at one
    function automatic logic [KEY_WIDTH-1:0] mod_power(logic [KEY_WIDTH-1:0] msg);
        logic [63:0]          acc;
        logic [63:0]          base;
        logic [KEY_WIDTH-1:0] bits;
        acc  = 64'd1;
        base = 64'(msg);
        bits = key_exp;
        for (int i = 0; i < KEY_WIDTH && bits != '0; i++) begin
            if (bits[0]) begin
                acc = reduce_by_key(acc * base);
            end
            base = reduce_by_key(base * base);
            bits = bits >> 1;
        end
        return acc[KEY_WIDTH-1:0];
    endfunction

    task automatic log_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request and hold it until accepted; valid stays high
    task automatic send_request(input logic [KEY_WIDTH-1:0] msg, input bit typed,
                                input logic [KEY_WIDTH-1:0] want);
        i_cfg_valid <= 1'b0;
        i_in_valid  <= 1'b1;
        i_message   <= msg;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        pending_powers = {pending_powers, (typed ? want : mod_power(msg))};
        requests_sent++;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge i_clk);
    endtask

    // Register write; valid is left high for back-to-back writes
    task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [KEY_WIDTH-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == REG_EXPONENT) begin
            key_exp = data;
        end else if (idx == REG_MODULUS) begin
            key_mod = data;
        end
        key_writes++;
    endtask

    // Bursts of back-to-back requests separated by gaps of random length
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            case ($urandom_range(0, 7))
                0:       gap = $urandom_range(50, 700);
                1, 2:    gap = 0;
                default: gap = $urandom_range(1, 40);
            endcase
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 6);
        end
    endtask

    // Mostly random messages, some at the edges of the current modulus
    function automatic logic [KEY_WIDTH-1:0] pick_message();
        if ($urandom_range(0, 9) != 0) begin
            return KEY_WIDTH'($urandom_range(0, 65535));
        end
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'd1;
            2:       return key_mod - 16'd1;
            3:       return key_mod;
            default: return '1;
        endcase
    endfunction

    // Key settings per phase: extremes first, then random keys
    task automatic load_phase_keys(input int phase);
        logic [KEY_WIDTH-1:0] new_exp;
        logic [KEY_WIDTH-1:0] new_mod;
        new_exp = KEY_WIDTH'($urandom_range(0, 65535));
        new_mod = KEY_WIDTH'($urandom_range(0, 65535));
        case (phase)
            0: begin new_exp = '1; new_mod = '1; end
            1: new_mod = '0;
            2: new_mod = 16'd1;
            3: new_exp = '0;
            4: new_mod = 16'd2;
            5: new_exp = 16'h8000;
            6: new_exp = 16'd1;
            7: new_exp = KEY_WIDTH'($urandom_range(0, 15));
            default: ;
        endcase
        if ($urandom_range(0, 1)) begin
            write_key_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          KEY_WIDTH'($urandom_range(0, 65535)));
        end
        if ($urandom_range(0, 1)) begin
            write_key_reg(REG_EXPONENT, new_exp);
            write_key_reg(REG_MODULUS, new_mod);
        end else begin
            write_key_reg(REG_MODULUS, new_mod);
            write_key_reg(REG_EXPONENT, new_exp);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Consumer stall: a random mode, redrawn when stall_window runs out, from never to always
    always @(posedge i_clk) begin
        if (stall_window == 0) begin
            stall_mode   <= $urandom_range(0, 3);
            stall_window <= 127;
        end else begin
            stall_window <= stall_window - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= 1'b1;
        endcase
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_powers.size() == 0) begin
                log_mismatch($sformatf("unexpected result %0d", o_power_result));
            end else begin
                if (o_power_result !== pending_powers[0]) begin
                    log_mismatch($sformatf("power_result %0d, want %0d",
                                           o_power_result, pending_powers[0]));
                end
                void'(pending_powers.pop_front());
                results_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit reached, %0d results outstanding",
                     pending_powers.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        directed_rows = '{
            // reset keys: exponent 1, modulus 65535
            '{ROW_REQ, REG_EXPONENT, 16'd0,     1'b1, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd65534, 1'b1, 16'd65534},
            '{ROW_REQ, REG_EXPONENT, 16'd65535, 1'b1, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd1,     1'b1, 16'd1},
            // zero exponent gives one, even for zero message and modulus one
            '{ROW_KEY, REG_EXPONENT, 16'd0,     1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd65535, 1'b1, 16'd1},
            '{ROW_REQ, REG_EXPONENT, 16'd0,     1'b1, 16'd1},
            '{ROW_KEY, REG_MODULUS,  16'd1,     1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd12345, 1'b1, 16'd1},
            '{ROW_KEY, REG_EXPONENT, 16'd5,     1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd65535, 1'b1, 16'd0},
            // zero modulus keeps the low bits of each product
            '{ROW_KEY, REG_MODULUS,  16'd0,     1'b0, 16'd0},
            '{ROW_KEY, REG_EXPONENT, 16'd2,     1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd65535, 1'b1, 16'd1},
            '{ROW_REQ, REG_EXPONENT, 16'd256,   1'b1, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd255,   1'b1, 16'd65025},
            '{ROW_KEY, REG_EXPONENT, 16'd65535, 1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd3,     1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd65535, 1'b1, 16'd65535},
            // full-width keys; message equal to modulus reduces to zero
            '{ROW_KEY, REG_MODULUS,  16'd65535, 1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd2,     1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd65535, 1'b1, 16'd0},
            // unused indexes must leave both keys alone
            '{ROW_KEY, REG_SPARE_2,  16'd1,     1'b0, 16'd0},
            '{ROW_KEY, REG_SPARE_3,  16'd0,     1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd2,     1'b0, 16'd0},
            // only the top exponent bit set, modulus two
            '{ROW_KEY, REG_MODULUS,  16'd2,     1'b0, 16'd0},
            '{ROW_KEY, REG_EXPONENT, 16'h8000,  1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd3,     1'b1, 16'd1},
            '{ROW_REQ, REG_EXPONENT, 16'd4,     1'b1, 16'd0},
            // message above and just below the modulus
            '{ROW_KEY, REG_MODULUS,  16'd1000,  1'b0, 16'd0},
            '{ROW_KEY, REG_EXPONENT, 16'd3,     1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd1234,  1'b0, 16'd0},
            '{ROW_REQ, REG_EXPONENT, 16'd999,   1'b0, 16'd0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_KEY) begin
                drain_results();
                write_key_reg(directed_rows[r].idx, directed_rows[r].value);
            end else begin
                send_request(directed_rows[r].value, directed_rows[r].typed,
                             directed_rows[r].want);
            end
        end

        // Random requests under a series of key settings
        for (int phase = 0; phase < KEY_PHASES; phase++) begin
            drain_results();
            load_phase_keys(phase);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                send_request(pick_message(), 1'b0, '0);
                pace_sender();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_powers.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", pending_powers.size()));
        end

        $display("Covered %0d requests, %0d results checked, %0d register writes,",
                 requests_sent, results_checked, key_writes);
        $display("%0d key phases incl. zero exponent and zero/one/two modulus, %0d cycles",
                 KEY_PHASES, cycle_count);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
